// ----- rtl/core/etnm_pkg.sv -----
// Package: shared types and constants for the extent table block.
package etnm_pkg;

    localparam int unsigned SLOTS_DEFAULT = 16;
    localparam logic [4:0]  DROP_MAX      = 5'd31;

    typedef enum logic [1:0] {
        FUNC_QUERY = 2'd0,
        FUNC_STAGE = 2'd1,
        FUNC_MERGE = 2'd2,
        FUNC_WRITE = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  slot;
        logic [31:0] start_block;
        logic [31:0] block_count;
        logic [31:0] current_block;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_block;
        logic        has_next;
        logic [4:0]  dropped_extents;
    } t_out_item;

    // Datapath command codes.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_QUERY  = 3'd1,
        OP_ABSORB = 3'd2,
        OP_PLACE  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_LOAD   = 3'd5
    } t_op;

    // Controller to datapath.
    typedef struct packed {
        t_op        op;
        logic [5:0] i;
        logic [5:0] j;
        logic       first;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic hit_stop;
        logic placed;
    } t_status;

endpackage

// ----- rtl/core/extent_table_next_and_merge.sv -----
// Top level: extent table with successor query and staged merge.
// A write or stage lands when the item is loaded; a query compares one slot per cycle.
// A merge runs an absorb pass that compares one file and one staged slot per cycle, then
// a placement pass that walks file slots for each staged extent until it finds an empty
// one, flagging a drop if it finds none; empty or absorbed staged extents are skipped.
// One item is in work at a time; the result is held in a register until transferred.
module extent_table_next_and_merge #(
    parameter int unsigned SLOTS = etnm_pkg::SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  etnm_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output etnm_pkg::t_out_item o_data
);

    etnm_pkg::t_cmd    w_cmd;
    etnm_pkg::t_status w_status;
    etnm_pkg::t_out_item w_res;

    etnm_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func(i_data.func),
        .i_out_ready(i_ready), .o_out_valid(o_valid),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    etnm_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk, .i_rst_n, .i_item(i_data), .i_cmd(w_cmd),
        .o_status(w_status), .o_result(w_res)
    );

    assign o_data = w_res;

endmodule

// ----- rtl/core/etnm_datapath.sv -----
// Datapath: extent tables, scan compare logic and result registers.
module etnm_datapath #(
    parameter int unsigned SLOTS = etnm_pkg::SLOTS_DEFAULT,
    parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etnm_pkg::t_in_item  i_item,
    input  etnm_pkg::t_cmd      i_cmd,
    output etnm_pkg::t_status   o_status,
    output etnm_pkg::t_out_item o_result
);

    logic [31:0] r_fs [SLOTS];
    logic [31:0] r_fl [SLOTS];
    logic [31:0] r_ss [SLOTS];
    logic [31:0] r_sl [SLOTS];
    logic [SLOTS-1:0] r_used;
    logic [32:0] r_after;
    logic [31:0] r_cur;
    logic [4:0]  r_lost;
    logic [31:0] r_ans;
    logic        r_found;
    logic        r_stop;

    logic [IW-1:0] w_i, w_j, w_slot;
    logic [32:0] w_end, w_sum, w_after;
    logic        w_match, w_inc, w_succ, w_cand, w_absorb;
    logic [31:0] w_sat;

    assign w_i    = i_cmd.i[IW-1:0];
    assign w_j    = i_cmd.j[IW-1:0];
    assign w_slot = IW'(i_item.slot);

    // Query compare for slot i.
    assign w_end   = {1'b0, r_fs[w_i]} + {1'b0, r_fl[w_i]};
    assign w_match = (r_fs[w_i] != 32'd0) && (r_cur >= r_fs[w_i]) && ({1'b0, r_cur} < w_end);
    assign w_inc   = (r_cur != 32'hFFFF_FFFF) && (({1'b0, r_cur} + 33'd1) < w_end);
    assign w_succ  = (i_cmd.i < 6'(SLOTS - 1)) && (r_fs[(w_i + IW'(1))] != 32'd0);

    // Staged extent j still waits for a home: not empty and not absorbed.
    assign w_cand = (r_ss[w_j] != 32'd0) && !r_used[w_j];

    // Absorb against the extent end taken at j == 0, before any growth in this pass.
    assign w_after  = i_cmd.first ? w_end : r_after;
    assign w_absorb = (r_fs[w_i] != 32'd0) && w_cand && ({1'b0, r_ss[w_j]} == w_after);

    // Absorb adder with saturation.
    assign w_sum = {1'b0, r_fl[w_i]} + {1'b0, r_sl[w_j]};
    assign w_sat = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];

    assign o_status.hit_stop = r_stop;
    assign o_status.placed   = !w_cand || (r_fs[w_i] == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_fs[k] <= '0;
                r_fl[k] <= '0;
                r_ss[k] <= '0;
                r_sl[k] <= '0;
            end
            r_used  <= '0;
            r_stop  <= 1'b0;
            r_found <= 1'b0;
            r_ans   <= '0;
            r_lost  <= '0;
        end else begin
            unique case (i_cmd.op)
                etnm_pkg::OP_LOAD: begin
                    // Latch operands; stage and write land here directly.
                    r_cur   <= i_item.current_block;
                    r_ans   <= '0;
                    r_found <= 1'b0;
                    r_stop  <= 1'b0;
                    r_lost  <= '0;
                    if ({3'b0, i_item.slot} < 7'(SLOTS)) begin
                        if (i_item.func == etnm_pkg::FUNC_STAGE) begin
                            r_ss[w_slot]   <= i_item.start_block;
                            r_sl[w_slot]   <= i_item.block_count;
                            r_used[w_slot] <= 1'b0;
                        end else if (i_item.func == etnm_pkg::FUNC_WRITE) begin
                            r_fs[w_slot] <= i_item.start_block;
                            r_fl[w_slot] <= i_item.block_count;
                        end
                    end
                end
                etnm_pkg::OP_QUERY: begin
                    if (!r_stop && w_match) begin
                        if (w_inc) begin
                            r_ans   <= r_cur + 32'd1;
                            r_found <= 1'b1;
                            r_stop  <= 1'b1;
                        end else if (w_succ) begin
                            r_ans   <= r_fs[(w_i + IW'(1))];
                            r_found <= 1'b1;
                        end
                    end
                end
                etnm_pkg::OP_ABSORB: begin
                    // Snapshot end from the pre-pass length at j == 0.
                    if (i_cmd.first) r_after <= w_end;
                    if (w_absorb) begin
                        r_fl[w_i]   <= w_sat;
                        r_used[w_j] <= 1'b1;
                    end
                end
                etnm_pkg::OP_PLACE: begin
                    // First empty slot takes staged extent j; first flags a drop.
                    if (i_cmd.first) begin
                        if (r_lost != etnm_pkg::DROP_MAX) r_lost <= r_lost + 5'd1;
                    end else if (w_cand && r_fs[w_i] == 32'd0) begin
                        r_fs[w_i] <= r_ss[w_j];
                        r_fl[w_i] <= r_sl[w_j];
                    end
                end
                etnm_pkg::OP_CLEAR: begin
                    for (int k = 0; k < SLOTS; k++) begin
                        r_ss[k] <= '0;
                        r_sl[k] <= '0;
                    end
                    r_used <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result.next_block      = r_ans;
    assign o_result.has_next        = r_found;
    assign o_result.dropped_extents = r_lost;

endmodule

// ----- rtl/core/etnm_ctrl.sv -----
// Controller: sequences query scans and the two merge passes.
module etnm_ctrl #(
    parameter int unsigned SLOTS = etnm_pkg::SLOTS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  etnm_pkg::t_status  i_status,
    output etnm_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_QUERY, S_ABSORB, S_PICK, S_PLACE, S_CLEAR, S_DONE}
        t_state;

    t_state     r_state;
    logic [5:0] r_i, r_j;
    logic       r_out_valid;

    localparam logic [5:0] LAST = 6'(SLOTS - 1);

    assign o_ready     = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    // Decode command from state.
    always_comb begin
        o_cmd.i     = r_i;
        o_cmd.j     = r_j;
        o_cmd.first = 1'b0;
        o_cmd.op    = etnm_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE:   o_cmd.op = (i_valid && o_ready) ? etnm_pkg::OP_LOAD : etnm_pkg::OP_NONE;
            S_QUERY:  o_cmd.op = etnm_pkg::OP_QUERY;
            S_ABSORB: begin
                o_cmd.op    = etnm_pkg::OP_ABSORB;
                o_cmd.first = (r_j == 6'd0);
            end
            S_PICK:   o_cmd.op = etnm_pkg::OP_NONE;
            S_PLACE:  begin
                o_cmd.op    = etnm_pkg::OP_PLACE;
                o_cmd.first = 1'b0;
            end
            S_CLEAR:  o_cmd.op = etnm_pkg::OP_CLEAR;
            S_DONE:   begin
                o_cmd.op    = etnm_pkg::OP_PLACE;
                o_cmd.first = 1'b1;
            end
            default:  o_cmd.op = etnm_pkg::OP_NONE;
        endcase
    end

    // Candidacy is checked by the datapath; absorb walks j per i, placement i per j.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_i <= '0;
                        r_j <= '0;
                        priority case (i_func)
                            etnm_pkg::FUNC_QUERY: r_state <= S_QUERY;
                            etnm_pkg::FUNC_MERGE: r_state <= S_ABSORB;
                            default:              r_out_valid <= 1'b1;
                        endcase
                    end
                end
                S_QUERY: begin
                    if (r_i == LAST) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_i <= r_i + 6'd1;
                    end
                end
                S_ABSORB: begin
                    if (r_j == LAST) begin
                        r_j <= '0;
                        if (r_i == LAST) begin
                            r_i     <= '0;
                            r_state <= S_PICK;
                        end else begin
                            r_i <= r_i + 6'd1;
                        end
                    end else begin
                        r_j <= r_j + 6'd1;
                    end
                end
                S_PICK: begin
                    // Candidate check happens in S_PLACE through placed status.
                    r_i     <= '0;
                    r_state <= S_PLACE;
                end
                S_PLACE: begin
                    if (!i_status.hit_stop && i_status.placed) begin
                        r_i <= '0;
                        if (r_j == LAST) r_state <= S_CLEAR;
                        else begin
                            r_j     <= r_j + 6'd1;
                            r_state <= S_PICK;
                        end
                    end else if (r_i == LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + 6'd1;
                    end
                end
                S_DONE: begin
                    r_i <= '0;
                    if (r_j == LAST) r_state <= S_CLEAR;
                    else begin
                        r_j     <= r_j + 6'd1;
                        r_state <= S_PICK;
                    end
                end
                S_CLEAR: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> r_out_valid)
        else $error("merge end without result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUERY && r_i == LAST) |=> (r_state == S_IDLE))
        else $error("query scan overrun");

endmodule

// ----- test/tb_extent_table_next_and_merge.sv -----
// Testbench for the extent table block: random and directed operations checked against a predictor.
module tb_extent_table_next_and_merge;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NSLOT = 16;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    etnm_pkg::t_in_item  i_data = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    etnm_pkg::t_out_item o_data;

    extent_table_next_and_merge #(.SLOTS(NSLOT)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    logic [31:0] ft_start [NSLOT];
    logic [31:0] ft_len [NSLOT];
    logic [31:0] st_start [NSLOT];
    logic [31:0] st_len [NSLOT];
    logic        st_absorbed [NSLOT];

    etnm_pkg::t_in_item  pending_ops[$];
    etnm_pkg::t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        query_hits = 0;
    int        merges_seen = 0;
    int        drops_seen = 0;
    bit        calm = 1'b0;

    // Apply one operation to the predicted tables and return its result.
    function automatic etnm_pkg::t_out_item predict_extent_op(etnm_pkg::t_in_item it);
        etnm_pkg::t_out_item r;
        logic [32:0] after;
        logic [32:0] sum;
        logic [4:0]  lost;
        bit          placed;
        r = '0;
        case (etnm_pkg::t_func'(it.func))
            etnm_pkg::FUNC_QUERY: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (ft_start[i] == 0) continue;
                    after = {1'b0, ft_start[i]} + {1'b0, ft_len[i]};
                    if (it.current_block < ft_start[i] || {1'b0, it.current_block} >= after)
                        continue;
                    if (it.current_block != 32'hFFFF_FFFF &&
                        {1'b0, it.current_block} + 33'd1 < after) begin
                        r.next_block = it.current_block + 32'd1;
                        r.has_next = 1'b1;
                        break;
                    end
                    if (i + 1 < NSLOT && ft_start[i+1] != 0) begin
                        r.next_block = ft_start[i+1];
                        r.has_next = 1'b1;
                    end
                end
            end
            etnm_pkg::FUNC_STAGE: begin
                st_start[it.slot] = it.start_block;
                st_len[it.slot] = it.block_count;
                st_absorbed[it.slot] = 1'b0;
            end
            etnm_pkg::FUNC_WRITE: begin
                ft_start[it.slot] = it.start_block;
                ft_len[it.slot] = it.block_count;
            end
            default: begin
                lost = '0;
                // Absorb staged extents that continue a file extent
                for (int i = 0; i < NSLOT; i++) begin
                    if (ft_start[i] == 0) continue;
                    after = {1'b0, ft_start[i]} + {1'b0, ft_len[i]};
                    for (int j = 0; j < NSLOT; j++) begin
                        if (st_start[j] != 0 && !st_absorbed[j] &&
                            {1'b0, st_start[j]} == after) begin
                            sum = {1'b0, ft_len[i]} + {1'b0, st_len[j]};
                            ft_len[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            st_absorbed[j] = 1'b1;
                        end
                    end
                end
                // Place the rest into empty slots
                for (int j = 0; j < NSLOT; j++) begin
                    if (st_start[j] == 0 || st_absorbed[j]) continue;
                    placed = 1'b0;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (ft_start[i] == 0) begin
                            ft_start[i] = st_start[j];
                            ft_len[i] = st_len[j];
                            placed = 1'b1;
                            break;
                        end
                    end
                    if (!placed && lost != etnm_pkg::DROP_MAX) lost++;
                end
                for (int j = 0; j < NSLOT; j++) begin
                    st_start[j] = '0;
                    st_len[j] = '0;
                    st_absorbed[j] = 1'b0;
                end
                r.dropped_extents = lost;
            end
        endcase
        return r;
    endfunction

    function automatic etnm_pkg::t_in_item make_op(etnm_pkg::t_func f, logic [3:0] s,
                                                   logic [31:0] sb, logic [31:0] bc,
                                                   logic [31:0] cb);
        etnm_pkg::t_in_item it;
        it.func = f;
        it.slot = s;
        it.start_block = sb;
        it.block_count = bc;
        it.current_block = cb;
        return it;
    endfunction

    function automatic logic [31:0] rand32();
        return $urandom();
    endfunction

    // Driver: present queued operations, idle at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                    i_data <= pending_ops.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // Record the expectation when an operation transfers
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(predict_extent_op(i_data));
            if (i_data.func == etnm_pkg::FUNC_MERGE) merges_seen++;
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        etnm_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result next=%h has=%b drop=%0d",
                             o_data.next_block, o_data.has_next, o_data.dropped_extents);
            end else begin
                want = expected_results.pop_front();
                if (want.has_next) query_hits++;
                if (want.dropped_extents != 0) drops_seen++;
                if (o_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp next=%h has=%b drop=%0d,",
                                  " got next=%h has=%b drop=%0d"},
                                 want.next_block, want.has_next, want.dropped_extents,
                                 o_data.next_block, o_data.has_next,
                                 o_data.dropped_extents);
                end
            end
        end
    end

    // Stimulus
    initial begin
        etnm_pkg::t_in_item it;
        logic [31:0] base;
        logic [31:0] ln;
        int          pick;
        for (int i = 0; i < NSLOT; i++) begin
            ft_start[i] = '0; ft_len[i] = '0;
            st_start[i] = '0; st_len[i] = '0; st_absorbed[i] = 1'b0;
        end

        // Directed: empty table, extents, last slot, top of block space, saturation, drops
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'd5));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_WRITE, 4'd0, 32'd100, 32'd10, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_WRITE, 4'd1, 32'd500, 32'd4, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'd100));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'd109));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'd110));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_WRITE, 4'd15, 32'hFFFF_FFF0,
                                      32'hFFFF_FFFF, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'hFFFF_FFF5));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_WRITE, 4'd2, 32'd200, 32'd0, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'd200));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_STAGE, 4'd0, 32'd110, 32'd5, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_STAGE, 4'd1, 32'd504, 32'hFFFF_FFFF, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_STAGE, 4'd2, 32'd110, 32'd2, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_STAGE, 4'd15, 32'd9000, 32'd3, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_STAGE, 4'd3, 32'd0, 32'd7, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_MERGE, 4'd0, 0, 0, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_QUERY, 4'd0, 0, 0, 32'd114));
        for (int i = 0; i < NSLOT; i++)
            pending_ops.push_back(make_op(etnm_pkg::FUNC_WRITE, 4'(i),
                                          32'd1000 + 32'(i) * 16, 32'd8, 0));
        for (int j = 0; j < NSLOT; j++)
            pending_ops.push_back(make_op(etnm_pkg::FUNC_STAGE, 4'(j),
                                          32'hFFFF_FFFF - 32'(j), 32'hFFFF_FFFF, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_MERGE, 4'd0, 0, 0, 0));
        pending_ops.push_back(make_op(etnm_pkg::FUNC_MERGE, 4'd0, 0, 0, 0));

        // Random: build extent chains, stage continuations, merge now and then
        for (int n = 0; n < 850; n++) begin
            pick = $urandom_range(99);
            base = ($urandom_range(9) == 0) ? rand32() : 32'($urandom_range(1, 4000));
            ln   = ($urandom_range(9) == 0) ? rand32() : 32'($urandom_range(0, 40));
            if (pick < 45) begin
                if ($urandom_range(3) == 0)
                    it = make_op(etnm_pkg::FUNC_QUERY, 4'($urandom_range(15)),
                                 rand32(), rand32(), rand32());
                else
                    it = make_op(etnm_pkg::FUNC_QUERY, 4'($urandom_range(15)),
                                 rand32(), rand32(), 32'($urandom_range(0, 4100)));
            end else if (pick < 68) begin
                it = make_op(etnm_pkg::FUNC_WRITE, 4'($urandom_range(15)), base, ln, rand32());
                if ($urandom_range(7) == 0) it.start_block = '0;
            end else if (pick < 95) begin
                it = make_op(etnm_pkg::FUNC_STAGE, 4'($urandom_range(15)), base, ln, rand32());
                if ($urandom_range(7) == 0) it.start_block = '0;
            end else begin
                it = make_op(etnm_pkg::FUNC_MERGE, 4'($urandom_range(15)),
                             rand32(), rand32(), rand32());
            end
            pending_ops.push_back(it);
        end
    end

    // Sequencing: reset, calm stretch, final drain
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3000) @(posedge i_clk);
        calm = 1'b1;
        repeat (6000) @(posedge i_clk);
        calm = 1'b0;
        wait (pending_ops.size() == 0 && !i_valid && expected_results.size() == 0);
        repeat (600) @(posedge i_clk);
        $display("covered %0d merges (%0d with drops) and %0d successful queries",
                 merges_seen, drops_seen, query_hits);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_extent_table_next_and_merge passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb_extent_table_next_and_merge failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("timeout");
        $display("tb_extent_table_next_and_merge failed");
        $finish;
    end
endmodule
